FILE: hdl/mdio22_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdio22_pkg
// Shared types and codes for the clause 22 management bus master.
// ----------------------------------------------------------------------------
package mdio22_pkg;

	// request kinds carried by each bit slot word
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;

	localparam int ADDR_W = 10;
	localparam int DATA_W = 16;

	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  phy_addr;
		logic [4:0]  reg_addr;
		logic [15:0] write_data;
		logic        mdio_in;
	} req_word_t;

	typedef struct packed {
		logic        mdio_out;
		logic        mdio_drive;
		logic        clock_pulse;
		logic        busy_res;
		logic        frame_done;
		logic [15:0] read_data;
	} rsp_word_t;

	// frame context held between slots (slot index travels beside it)
	typedef struct packed {
		logic              active;
		logic              is_read;
		logic [ADDR_W-1:0] addr_shift;
		logic [DATA_W-1:0] data_shift;
	} frame_ctx_t;

endpackage

FILE: hdl/mdio_clause22_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdio_clause22_master
// Clause 22 management bus master; one word in and one word out per MDC slot.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake             | word
//  --------+-----+-----------------------+-------------------------------------
//  req     | in  | req_valid / req_stall | kind, addresses, write data, sample
//  rsp     | out | rsp_valid / rsp_stall | line level, drive, MDC, busy, done
//
//  Each slot word passes through the input register, then the result register.
//  A new word is taken every cycle while req_stall is low; throughput is then
//  one slot per cycle, set by the combinational slot evaluation feeding state.
//  Reset clears the frame context, slot index and both valid flags.
//  A stall on rsp holds the result register and then the input register;
//  req_stall rises only when the input register is full and cannot drain.
//
module mdio_clause22_master #(
	parameter int PREAMBLE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  mdio22_pkg::req_word_t req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output mdio22_pkg::rsp_word_t rsp
);
	import mdio22_pkg::*;

	// slot index must reach the trailing slot, preamble plus 32
	localparam int SLOT_W = $clog2(PREAMBLE_BITS + 33);

	req_word_t         req_s1;
	logic              valid_s1;
	rsp_word_t         rsp_s2;
	logic              valid_s2;
	frame_ctx_t        ctx_q;
	logic [SLOT_W-1:0] slot_q;

	frame_ctx_t        ctx_next;
	logic [SLOT_W-1:0] slot_next;
	rsp_word_t         rsp_next;
	logic              advance;
	logic              take;

	// advance the input word when the result register is empty or draining
	assign advance   = valid_s1 && (!valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign take      = req_valid && !req_stall;

	mdio22_slot_eval #(
		.PREAMBLE_BITS(PREAMBLE_BITS),
		.SLOT_W       (SLOT_W)
	) u_eval (
		.req      (req_s1),
		.ctx      (ctx_q),
		.slot     (slot_q),
		.ctx_next (ctx_next),
		.slot_next(slot_next),
		.rsp      (rsp_next)
	);

	// input register: capture on accept, drop the flag once evaluated
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1 <= req;
		end
	end

	// frame state: commit only when the slot word moves to the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q  <= '0;
			slot_q <= '0;
		end else if (advance) begin
			ctx_q  <= ctx_next;
			slot_q <= slot_next;
		end
	end

	// result register: hold while stalled, clear the flag once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!rsp_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= rsp_next;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

endmodule

FILE: hdl/mdio22_slot_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdio22_slot_eval
// Evaluates one bit slot: line level, drive, clock and next frame context.
// ----------------------------------------------------------------------------
module mdio22_slot_eval #(
	parameter int PREAMBLE_BITS = 32,
	parameter int SLOT_W        = 7
) (
	input  mdio22_pkg::req_word_t  req,
	input  mdio22_pkg::frame_ctx_t ctx,
	input  logic [SLOT_W-1:0]      slot,
	output mdio22_pkg::frame_ctx_t ctx_next,
	output logic [SLOT_W-1:0]      slot_next,
	output mdio22_pkg::rsp_word_t  rsp
);
	import mdio22_pkg::*;

	localparam logic [SLOT_W-1:0] S_ST0  = SLOT_W'(PREAMBLE_BITS);
	localparam logic [SLOT_W-1:0] S_ST1  = SLOT_W'(PREAMBLE_BITS + 1);
	localparam logic [SLOT_W-1:0] S_OP0  = SLOT_W'(PREAMBLE_BITS + 2);
	localparam logic [SLOT_W-1:0] S_OP1  = SLOT_W'(PREAMBLE_BITS + 3);
	localparam logic [SLOT_W-1:0] S_ADR  = SLOT_W'(PREAMBLE_BITS + 4);
	localparam logic [SLOT_W-1:0] S_TA0  = SLOT_W'(PREAMBLE_BITS + 14);
	localparam logic [SLOT_W-1:0] S_TA1  = SLOT_W'(PREAMBLE_BITS + 15);
	localparam logic [SLOT_W-1:0] S_DAT  = SLOT_W'(PREAMBLE_BITS + 16);
	localparam logic [SLOT_W-1:0] S_TAIL = SLOT_W'(PREAMBLE_BITS + 32);

	logic              start;
	frame_ctx_t        cur;
	logic [SLOT_W-1:0] s;
	logic [SLOT_W-1:0] s_adr_off;
	logic [SLOT_W-1:0] s_dat_off;
	logic [3:0]        adr_bit;
	logic [3:0]        dat_bit;
	logic              done;

	always_comb begin
		start = !ctx.active && (req.kind == KIND_READ || req.kind == KIND_WRITE);
		cur   = ctx;
		s     = slot;
		if (start) begin
			cur.active     = 1'b1;
			cur.is_read    = (req.kind == KIND_READ);
			cur.addr_shift = {req.phy_addr, req.reg_addr};
			cur.data_shift = (req.kind == KIND_READ) ? '0 : req.write_data;
			s              = '0;
		end
	end

	assign s_adr_off = s - S_ADR;
	assign s_dat_off = s - S_DAT;
	assign adr_bit   = 4'd9 - s_adr_off[3:0];
	assign dat_bit   = 4'd15 - s_dat_off[3:0];

	always_comb begin
		ctx_next        = cur;
		rsp.mdio_out    = 1'b1;
		rsp.mdio_drive  = 1'b1;
		rsp.clock_pulse = cur.active;
		rsp.busy_res    = cur.active;
		rsp.read_data   = '0;
		done            = 1'b0;
		if (cur.active) begin
			if (s < S_ST0) begin
				rsp.mdio_out = 1'b1;
			end else if (s == S_ST0) begin
				rsp.mdio_out = 1'b0;
			end else if (s == S_ST1) begin
				rsp.mdio_out = 1'b1;
			end else if (s == S_OP0) begin
				rsp.mdio_out = cur.is_read;
			end else if (s == S_OP1) begin
				rsp.mdio_out = !cur.is_read;
			end else if (s < S_TA0) begin
				rsp.mdio_out = cur.addr_shift[adr_bit];
			end else if (s == S_TA0) begin
				// read turnaround: release the line for the PHY
				rsp.mdio_drive = !cur.is_read;
			end else if (s == S_TA1) begin
				rsp.mdio_out = 1'b0;
			end else if (s < S_TAIL) begin
				if (cur.is_read) begin
					rsp.mdio_drive      = 1'b0;
					ctx_next.data_shift = {cur.data_shift[DATA_W-2:0], req.mdio_in};
				end else begin
					rsp.mdio_out = cur.data_shift[dat_bit];
				end
			end else begin
				done = 1'b1;
				if (cur.is_read) begin
					rsp.mdio_drive = 1'b0;
					rsp.read_data  = cur.data_shift;
				end else begin
					rsp.mdio_out = cur.data_shift[0];
				end
			end
		end
		rsp.frame_done = done;
		if (done) begin
			ctx_next.active = 1'b0;
			slot_next       = '0;
		end else if (cur.active) begin
			slot_next = s + 1'b1;
		end else begin
			slot_next = s;
		end
	end

endmodule
